FILE: hw/rtl/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared sizes, codes and types of the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
package ssf_pkg;

   localparam int unsigned BLOCK_RANGE   = 4096;
   localparam int unsigned QUEUE_DEPTH   = 64;
   localparam int unsigned TAG_BITS      = 16;

   localparam int unsigned POS_BITS      = 12;
   localparam int unsigned SLOT_BITS     = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned TOTAL_BITS    = 32;

   localparam int unsigned FIFO_DEPTH    = 2;
   localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam logic [POS_BITS-1:0]   POS_MAX   = POS_BITS'(BLOCK_RANGE - 1);
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   typedef enum logic [0:0] {
      OP_ADD   = 1'b0,
      OP_SERVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_ADDED  = 2'd0,
      ST_SERVED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_FIND,
      ENG_SCAN,
      ENG_LAST,
      ENG_DONE
   } eng_state_type;

   // one classified word between front and back
   typedef struct packed {
      op_type              op;
      logic [POS_BITS-1:0] pos;
      logic [TAG_BITS-1:0] tag;
   } cmd_type;

   // one result word
   typedef struct packed {
      status_type            status;
      logic [POS_BITS-1:0]   served_position;
      logic [TAG_BITS-1:0]   served_tag;
      logic [POS_BITS-1:0]   seek_distance;
      logic [TOTAL_BITS-1:0] total_seek;
      logic [CNT_BITS-1:0]   pending_count;
   } rsp_type;

   // limit a position to the block range
   function automatic logic [POS_BITS-1:0] clamp_pos(input logic [POS_BITS-1:0] p);
      logic [POS_BITS-1:0] r;
      r = p;
      if (p > POS_MAX) begin
         r = POS_MAX;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/ssf_front.sv
// ----------------------------------------------------------------------------
// ssf_front
// Input stage: accepts request words, decodes and clamps them, and holds
// one classified word until the command queue takes it.
// ----------------------------------------------------------------------------
module ssf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [ssf_pkg::POS_BITS-1:0] req_block_position,
   input  logic [ssf_pkg::TAG_BITS-1:0] req_batch_tag,
   output logic                         push_valid,
   input  logic                         push_ready,
   output ssf_pkg::cmd_type             push_cmd
);

   logic             hold_valid_ff, hold_valid_in;
   ssf_pkg::cmd_type hold_cmd_ff, hold_cmd_in;
   logic             req_take;

   assign req_ready  = !hold_valid_ff || push_ready;
   assign req_take   = req_valid && req_ready;
   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_cmd_ff;

   // classify the incoming word, hold it until pushed
   always_comb begin
      hold_cmd_in   = hold_cmd_ff;
      hold_valid_in = hold_valid_ff;
      if (push_ready) begin
         hold_valid_in = 1'b0;
      end
      if (req_take) begin
         hold_valid_in   = 1'b1;
         hold_cmd_in.op  = req_operation ? ssf_pkg::OP_SERVE : ssf_pkg::OP_ADD;
         hold_cmd_in.pos = ssf_pkg::clamp_pos(req_block_position);
         hold_cmd_in.tag = req_batch_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

FILE: hw/rtl/ssf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ssf_cmd_fifo
// Short command queue between the front stage and the scheduling engine.
// ----------------------------------------------------------------------------
module ssf_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ssf_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ssf_pkg::cmd_type pop_cmd
);

   ssf_pkg::cmd_type                    entry_ff [ssf_pkg::FIFO_DEPTH];
   logic [ssf_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ssf_pkg::FIFO_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ssf_pkg::FIFO_CNT_BITS-1:0]   count_ff, count_in;
   logic                                do_push, do_pop;

   assign push_ready = count_ff != ssf_pkg::FIFO_CNT_BITS'(ssf_pkg::FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ssf_pkg::FIFO_PTR_BITS'(ssf_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ssf_pkg::FIFO_PTR_BITS'(ssf_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hw/rtl/ssf_engine.sv
// ----------------------------------------------------------------------------
// ssf_engine
// Scheduling engine: keeps the request table, places adds in the lowest free
// slot by a slot-by-slot search and serves the nearest request by a full
// sweep of the table memory, then registers the result word.
// ----------------------------------------------------------------------------
module ssf_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  ssf_pkg::cmd_type             cmd,
   input  logic                         csr_write_enable,
   input  logic [ssf_pkg::POS_BITS-1:0] csr_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ssf_pkg::rsp_type             rsp
);

   localparam logic [ssf_pkg::SLOT_BITS-1:0] LAST_SLOT =
      ssf_pkg::SLOT_BITS'(ssf_pkg::QUEUE_DEPTH - 1);
   localparam logic [ssf_pkg::CNT_BITS-1:0] FULL_COUNT =
      ssf_pkg::CNT_BITS'(ssf_pkg::QUEUE_DEPTH);

   // request table
   logic [ssf_pkg::POS_BITS-1:0] pos_mem [ssf_pkg::QUEUE_DEPTH];
   logic [ssf_pkg::TAG_BITS-1:0] tag_mem [ssf_pkg::QUEUE_DEPTH];
   logic [ssf_pkg::POS_BITS-1:0] rd_pos_ff;
   logic [ssf_pkg::TAG_BITS-1:0] rd_tag_ff;
   logic                         mem_we;

   ssf_pkg::eng_state_type         state_ff, state_in;
   ssf_pkg::cmd_type               cmd_ff, cmd_in;
   logic [ssf_pkg::SLOT_BITS-1:0]  idx_ff, idx_in;
   logic [ssf_pkg::QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [ssf_pkg::CNT_BITS-1:0]   count_ff, count_in;
   logic [ssf_pkg::POS_BITS-1:0]   head_ff, head_in;
   logic [ssf_pkg::TOTAL_BITS-1:0] total_ff, total_in;
   logic                           moved_ff, moved_in;
   ssf_pkg::status_type            res_status_ff, res_status_in;

   // compare stage of the sweep
   logic                           p1_valid_ff, p1_valid_in;
   logic [ssf_pkg::SLOT_BITS-1:0]  p1_idx_ff;
   logic                           found_ff, found_in;
   logic [ssf_pkg::SLOT_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [ssf_pkg::POS_BITS-1:0]   best_d_ff, best_d_in;
   logic [ssf_pkg::POS_BITS-1:0]   best_pos_ff, best_pos_in;
   logic [ssf_pkg::TAG_BITS-1:0]   best_tag_ff, best_tag_in;
   logic [ssf_pkg::POS_BITS-1:0]   gap;
   logic                           take;

   logic                           rsp_valid_ff, rsp_valid_in;
   ssf_pkg::rsp_type               rsp_ff, rsp_in;
   logic                           out_free;
   logic [ssf_pkg::TOTAL_BITS:0]   sum;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = state_ff == ssf_pkg::ENG_IDLE;

   // distance of the slot read last cycle and whether it is the new best
   always_comb begin
      gap  = (rd_pos_ff >= head_ff) ? rd_pos_ff - head_ff : head_ff - rd_pos_ff;
      take = p1_valid_ff && valid_ff[p1_idx_ff] && (!found_ff || gap < best_d_ff);
      sum  = {1'b0, total_ff} + (ssf_pkg::TOTAL_BITS + 1)'(best_d_ff);
   end

   // sequencer, table bookkeeping and result register
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      moved_in      = moved_ff;
      res_status_in = res_status_ff;
      p1_valid_in   = 1'b0;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_d_in     = best_d_ff;
      best_pos_in   = best_pos_ff;
      best_tag_in   = best_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;

      // head follows the start position until the first serve
      if (csr_write_enable && !moved_ff) begin
         head_in = ssf_pkg::clamp_pos(csr_write_data);
      end

      if (take) begin
         found_in    = 1'b1;
         best_idx_in = p1_idx_ff;
         best_d_in   = gap;
         best_pos_in = rd_pos_ff;
         best_tag_in = rd_tag_ff;
      end

      case (state_ff)
         ssf_pkg::ENG_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               idx_in = '0;
               if (cmd.op == ssf_pkg::OP_ADD) begin
                  if (count_ff == FULL_COUNT) begin
                     res_status_in = ssf_pkg::ST_FULL;
                     state_in      = ssf_pkg::ENG_DONE;
                  end else begin
                     state_in = ssf_pkg::ENG_FIND;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = ssf_pkg::ST_EMPTY;
                     state_in      = ssf_pkg::ENG_DONE;
                  end else begin
                     found_in = 1'b0;
                     state_in = ssf_pkg::ENG_SCAN;
                  end
               end
            end
         end
         ssf_pkg::ENG_FIND: begin
            // a free slot exists, so the search stops before the end
            if (!valid_ff[idx_ff]) begin
               mem_we           = 1'b1;
               valid_in[idx_ff] = 1'b1;
               count_in         = count_ff + 1'b1;
               res_status_in    = ssf_pkg::ST_ADDED;
               state_in         = ssf_pkg::ENG_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ssf_pkg::ENG_SCAN: begin
            p1_valid_in = 1'b1;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == LAST_SLOT) begin
               state_in = ssf_pkg::ENG_LAST;
            end
         end
         ssf_pkg::ENG_LAST: begin
            res_status_in = ssf_pkg::ST_SERVED;
            state_in      = ssf_pkg::ENG_DONE;
         end
         ssf_pkg::ENG_DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = res_status_ff;
               rsp_in.served_position = '0;
               rsp_in.served_tag      = '0;
               rsp_in.seek_distance   = '0;
               rsp_in.total_seek      = total_ff;
               rsp_in.pending_count   = count_ff;
               if (res_status_ff == ssf_pkg::ST_SERVED) begin
                  total_in = sum[ssf_pkg::TOTAL_BITS] ? ssf_pkg::TOTAL_MAX :
                             sum[ssf_pkg::TOTAL_BITS-1:0];
                  head_in                = best_pos_ff;
                  moved_in               = 1'b1;
                  valid_in[best_idx_ff]  = 1'b0;
                  count_in               = count_ff - 1'b1;
                  rsp_in.served_position = best_pos_ff;
                  rsp_in.served_tag      = best_tag_ff;
                  rsp_in.seek_distance   = best_d_ff;
                  rsp_in.total_seek      = sum[ssf_pkg::TOTAL_BITS] ? ssf_pkg::TOTAL_MAX :
                                           sum[ssf_pkg::TOTAL_BITS-1:0];
                  rsp_in.pending_count   = count_ff - 1'b1;
               end
               state_in = ssf_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = ssf_pkg::ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssf_pkg::ENG_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         total_ff     <= '0;
         moved_ff     <= 1'b0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         moved_ff     <= moved_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      p1_idx_ff     <= idx_ff;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_d_ff     <= best_d_in;
      best_pos_ff   <= best_pos_in;
      best_tag_ff   <= best_tag_in;
      rsp_ff        <= rsp_in;
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem[idx_ff] <= cmd_ff.pos;
         tag_mem[idx_ff] <= cmd_ff.tag;
      end
      rd_pos_ff <= pos_mem[idx_ff];
      rd_tag_ff <= tag_mem[idx_ff];
   end

endmodule

FILE: hw/rtl/shortest_seek_first_scheduler.sv
// ----------------------------------------------------------------------------
// shortest_seek_first_scheduler
// Shortest-seek-first disk request scheduler with a 64-slot request table.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per handshake: operation 0 adds block_position and
//   batch_tag to the table, operation 1 serves the pending request nearest the
//   head (ties to the lowest slot). Every word yields one rsp_* word with the
//   status, the served request, the seek distance, the saturating seek total
//   and the number of pending requests.
//   csr_write_data sets the start position; it also moves the head while no
//   serve has happened since reset.
// Flow:
//   A word passes the front hold register and the two-entry queue before the
//   engine takes it. An add searches slot by slot for the lowest free slot,
//   a serve sweeps all 64 entries through the memory read port, and full and
//   empty go straight to the result. The engine takes one word at a time: a
//   new word only once the result of the last one is registered.
// Reset and stalls:
//   Reset empties the table, clears the total and sets the head to zero; no
//   clearing pass is needed. While rsp_ready is low the result is held, the
//   engine may start the next word and the queue accepts words until it is full.
// ----------------------------------------------------------------------------
module shortest_seek_first_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [ssf_pkg::POS_BITS-1:0]   req_block_position,
   input  logic [ssf_pkg::TAG_BITS-1:0]   req_batch_tag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [ssf_pkg::POS_BITS-1:0]   rsp_served_position,
   output logic [ssf_pkg::TAG_BITS-1:0]   rsp_served_tag,
   output logic [ssf_pkg::POS_BITS-1:0]   rsp_seek_distance,
   output logic [ssf_pkg::TOTAL_BITS-1:0] rsp_total_seek,
   output logic [ssf_pkg::CNT_BITS-1:0]   rsp_pending_count,
   input  logic                           csr_write_enable,
   input  logic [ssf_pkg::POS_BITS-1:0]   csr_write_data
);

   logic             push_valid, push_ready;
   ssf_pkg::cmd_type push_cmd;
   logic             pop_valid, pop_ready;
   ssf_pkg::cmd_type pop_cmd;
   ssf_pkg::rsp_type rsp;

   ssf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_block_position (req_block_position),
      .req_batch_tag      (req_batch_tag),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_cmd           (push_cmd)
   );

   ssf_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   ssf_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (pop_valid),
      .cmd_ready        (pop_ready),
      .cmd              (pop_cmd),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp)
   );

   // unpack the result word onto the ports
   assign rsp_status          = rsp.status;
   assign rsp_served_position = rsp.served_position;
   assign rsp_served_tag      = rsp.served_tag;
   assign rsp_seek_distance   = rsp.seek_distance;
   assign rsp_total_seek      = rsp.total_seek;
   assign rsp_pending_count   = rsp.pending_count;

endmodule

FILE: hw/rtl/ssf_checker.sv
// ----------------------------------------------------------------------------
// ssf_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ssf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_operation,
   input logic [ssf_pkg::POS_BITS-1:0]   req_block_position,
   input logic [ssf_pkg::TAG_BITS-1:0]   req_batch_tag,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [1:0]                     rsp_status,
   input logic [ssf_pkg::POS_BITS-1:0]   rsp_served_position,
   input logic [ssf_pkg::TAG_BITS-1:0]   rsp_served_tag,
   input logic [ssf_pkg::POS_BITS-1:0]   rsp_seek_distance,
   input logic [ssf_pkg::TOTAL_BITS-1:0] rsp_total_seek,
   input logic [ssf_pkg::CNT_BITS-1:0]   rsp_pending_count,
   input logic                           csr_write_enable,
   input logic [ssf_pkg::POS_BITS-1:0]   csr_write_data
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_served_position) && $stable(rsp_served_tag) &&
      $stable(rsp_seek_distance) && $stable(rsp_total_seek) &&
      $stable(rsp_pending_count))
      else $error("result word changed while stalled");

   // drop served fields on anything but a serve
   a_unserved_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ssf_pkg::ST_SERVED |->
      rsp_served_position == '0 && rsp_served_tag == '0 && rsp_seek_distance == '0)
      else $error("served fields set on a non-serve result");

   // full and empty answers agree with the pending count
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (rsp_status != ssf_pkg::ST_FULL ||
       rsp_pending_count == ssf_pkg::CNT_BITS'(ssf_pkg::QUEUE_DEPTH)) &&
      (rsp_status != ssf_pkg::ST_EMPTY || rsp_pending_count == '0) &&
      rsp_pending_count <= ssf_pkg::CNT_BITS'(ssf_pkg::QUEUE_DEPTH))
      else $error("pending count disagrees with status");

   // the running total never trails the last distance
   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ssf_pkg::ST_SERVED |->
      rsp_total_seek >= ssf_pkg::TOTAL_BITS'(rsp_seek_distance))
      else $error("seek total below seek distance");

   // no result directly after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind shortest_seek_first_scheduler ssf_checker u_checker (.*);
